@@ hdl/bbps_pkg.sv @@
// Shared types, constants and field helpers for the buzzer beep pattern sequencer.
// Used by every module in this folder; depends on nothing else.
package bbps_pkg;

  localparam int TickBits  = 16;
  localparam int FieldBits = 16;
  localparam int WordBits  = 48;
  localparam int NumPats   = 6;
  localparam int IdxBits   = 3;

  localparam logic [FieldBits-1:0] ForeverCount = 16'hffff;
  localparam logic [TickBits-1:0]  TickOnes     = {TickBits{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [2:0] PatIdle     = 3'd0;
  localparam logic [2:0] PatKey      = 3'd1;
  localparam logic [2:0] PatNear     = 3'd2;
  localparam logic [2:0] PatAuto     = 3'd3;
  localparam logic [2:0] PatLocked   = 3'd4;
  localparam logic [2:0] PatUnlocked = 3'd5;
  localparam logic [2:0] PatEnd      = 3'd6;

  localparam logic [IdxBits-1:0] RegKey       = 3'd0;
  localparam logic [IdxBits-1:0] RegNear      = 3'd1;
  localparam logic [IdxBits-1:0] RegAuto      = 3'd2;
  localparam logic [IdxBits-1:0] RegLocked    = 3'd3;
  localparam logic [IdxBits-1:0] RegUnlocked  = 3'd4;
  localparam logic [IdxBits-1:0] RegEnd       = 3'd5;
  localparam logic [IdxBits-1:0] RegNearFirst = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] pattern;
  } in_item_t;

  typedef struct packed {
    logic buzzer_level;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic [NumPats-1:0][WordBits-1:0] pattern;
    logic [FieldBits-1:0]             near_first_on;
  } cfg_t;

  function automatic logic [TickBits-1:0] to_ticks(logic [FieldBits-1:0] f);
    logic [31:0] w;
    w = 32'(f);
    return w[TickBits-1:0];
  endfunction

  function automatic logic [WordBits-1:0] pat_word(cfg_t c, logic [2:0] p);
    logic [WordBits-1:0] w;
    case (p)
      PatKey:      w = c.pattern[0];
      PatNear:     w = c.pattern[1];
      PatAuto:     w = c.pattern[2];
      PatLocked:   w = c.pattern[3];
      PatUnlocked: w = c.pattern[4];
      PatEnd:      w = c.pattern[5];
      default:     w = c.pattern[0];
    endcase
    return w;
  endfunction

  function automatic logic [TickBits-1:0] pat_on(cfg_t c, logic [2:0] p);
    logic [WordBits-1:0] w;
    w = pat_word(c, p);
    return to_ticks(w[15:0]);
  endfunction

  function automatic logic [TickBits-1:0] pat_off(cfg_t c, logic [2:0] p);
    logic [WordBits-1:0] w;
    w = pat_word(c, p);
    return to_ticks(w[31:16]);
  endfunction

  function automatic logic [FieldBits-1:0] pat_count(cfg_t c, logic [2:0] p);
    logic [WordBits-1:0] w;
    w = pat_word(c, p);
    return w[47:32];
  endfunction

endpackage

@@ hdl/bbps_cfg_regs.sv @@
// Configuration register file: six pattern words and the near first on-time.
// Depends on bbps_pkg.
module bbps_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bbps_pkg::IdxBits-1:0]          cfg_index_i,
  input  logic [bbps_pkg::WordBits-1:0]         cfg_data_i,
  output bbps_pkg::cfg_t                        cfg_o
);

  bbps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bbps_pkg::RegKey:       cfg_q.pattern[0] <= cfg_data_i;
        bbps_pkg::RegNear:      cfg_q.pattern[1] <= cfg_data_i;
        bbps_pkg::RegAuto:      cfg_q.pattern[2] <= cfg_data_i;
        bbps_pkg::RegLocked:    cfg_q.pattern[3] <= cfg_data_i;
        bbps_pkg::RegUnlocked:  cfg_q.pattern[4] <= cfg_data_i;
        bbps_pkg::RegEnd:       cfg_q.pattern[5] <= cfg_data_i;
        bbps_pkg::RegNearFirst: cfg_q.near_first_on <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/bbps_core.sv @@
// Pattern state and its single-step update for one command word.
// Depends on bbps_pkg.
module bbps_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bbps_pkg::in_item_t  item_i,
  input  bbps_pkg::cfg_t      cfg_i,
  output bbps_pkg::out_item_t res_o
);

  logic [2:0]                          active_q, active_d;
  logic                                in_gap_q, in_gap_d;
  logic [bbps_pkg::TickBits-1:0]       on_q, on_d;
  logic [bbps_pkg::TickBits-1:0]       off_q, off_d;
  logic [bbps_pkg::FieldBits-1:0]      rep_q, rep_d;
  logic                                drive_q, drive_d;
  logic [bbps_pkg::FieldBits-1:0]      rep_dec;
  logic [2:0]                          pat;

  always_comb begin
    active_d = active_q;
    in_gap_d = in_gap_q;
    on_d     = on_q;
    off_d    = off_q;
    rep_d    = rep_q;
    drive_d  = drive_q;
    pat      = item_i.pattern;
    rep_dec  = rep_q;
    if (rep_q != bbps_pkg::ForeverCount && rep_q != '0) begin
      rep_dec = rep_q - 1'b1;
    end
    case (bbps_pkg::cmd_e'(item_i.command))
      bbps_pkg::CMD_TICK: begin
        if (active_q != bbps_pkg::PatIdle) begin
          if (!in_gap_q) begin
            if (on_q != '0) begin
              on_d = on_q - 1'b1;
            end else begin
              drive_d = 1'b0;
              on_d    = bbps_pkg::TickOnes;
              rep_d   = rep_dec;
              if (rep_dec != '0) begin
                off_d    = bbps_pkg::pat_off(cfg_i, active_q);
                in_gap_d = 1'b1;
              end else begin
                off_d    = bbps_pkg::TickOnes;
                in_gap_d = 1'b0;
                active_d = bbps_pkg::PatIdle;
              end
            end
          end else begin
            if (off_q != '0) begin
              off_d = off_q - 1'b1;
            end else begin
              off_d    = bbps_pkg::TickOnes;
              in_gap_d = 1'b0;
              if (rep_q != '0) begin
                drive_d = 1'b1;
                on_d    = bbps_pkg::pat_on(cfg_i, active_q);
              end else begin
                on_d     = bbps_pkg::TickOnes;
                active_d = bbps_pkg::PatIdle;
              end
            end
          end
        end
      end
      bbps_pkg::CMD_START: begin
        if ((pat inside {[bbps_pkg::PatKey:bbps_pkg::PatEnd]})
            && !(pat == bbps_pkg::PatKey && active_q != bbps_pkg::PatIdle)
            && !(pat == bbps_pkg::PatNear && active_q == bbps_pkg::PatNear)) begin
          active_d = pat;
          in_gap_d = 1'b0;
          off_d    = bbps_pkg::TickOnes;
          if (pat == bbps_pkg::PatNear) begin
            on_d = bbps_pkg::to_ticks(cfg_i.near_first_on);
          end else begin
            on_d = bbps_pkg::pat_on(cfg_i, pat);
          end
          rep_d   = bbps_pkg::pat_count(cfg_i, pat);
          drive_d = 1'b1;
        end
      end
      bbps_pkg::CMD_STOP: begin
        active_d = bbps_pkg::PatIdle;
        in_gap_d = 1'b0;
        on_d     = bbps_pkg::TickOnes;
        off_d    = bbps_pkg::TickOnes;
        rep_d    = bbps_pkg::ForeverCount;
        drive_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= bbps_pkg::PatIdle;
      in_gap_q <= 1'b0;
      on_q     <= bbps_pkg::TickOnes;
      off_q    <= bbps_pkg::TickOnes;
      rep_q    <= '0;
      drive_q  <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      in_gap_q <= in_gap_d;
      on_q     <= on_d;
      off_q    <= off_d;
      rep_q    <= rep_d;
      drive_q  <= drive_d;
    end
  end

  assign res_o.buzzer_level = drive_d;
  assign res_o.busy_res     = (active_d != bbps_pkg::PatIdle);

endmodule

@@ hdl/buzzer_beep_pattern_sequencer.sv @@
// Top level of the buzzer beep pattern sequencer: input register, state update, result register.
// Depends on bbps_pkg, bbps_cfg_regs and bbps_core.
//
// Every accepted command word (tick, start, stop or none) yields exactly one result word with
// the buzzer level and the busy flag after that command. A word is taken into the input
// register and applied to the pattern state at the clock edge on which it advances, where its
// result is loaded into the result register; while the result register is stalled, the word
// waits in the input register. One word is accepted per cycle for as long as results are
// taken; the single state-update step between the two registers sets that figure.
// Configuration writes take effect at once and belong to idle periods.
module buzzer_beep_pattern_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bbps_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bbps_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [bbps_pkg::IdxBits-1:0]  cfg_index_i,
  input  logic [bbps_pkg::WordBits-1:0] cfg_data_i
);

  bbps_pkg::cfg_t      cfg;
  bbps_pkg::in_item_t  in_item_q;
  bbps_pkg::out_item_t out_item_q;
  bbps_pkg::out_item_t res;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  bbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bbps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
